// File: design/assert_macros.svh
// Shared assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mpbb_pkg.sv
package mpbb_pkg;

    localparam int MAX_DIM_DEF = 2048;

    localparam int DIM_W   = 12;
    localparam int CH_W    = 8;
    localparam int BOX_W   = 12;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [DIM_W-1:0] WIDTH_RST   = 12'd2048;
    localparam logic [DIM_W-1:0] HEIGHT_RST  = 12'd2048;
    localparam logic [CH_W-1:0]  THRESH_RST  = 8'd100;
    localparam logic [DIM_W-1:0] MIN_BOX_RST = 12'd10;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_THRESH  = 2'd2,
        REG_MIN_BOX = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [CH_W-1:0]  thresh;
        logic [DIM_W-1:0] min_box;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_pix;

    typedef struct packed {
        logic [BOX_W-1:0] left;
        logic [BOX_W-1:0] right;
        logic [BOX_W-1:0] top;
        logic [BOX_W-1:0] bottom;
        logic             too_small;
    } t_box;

    // write strobes into the result buffer
    typedef struct packed {
        logic pix_we;
        logic sum_we;
    } t_out_wr;

endpackage

// File: design/masked_premultiply_bounding_box_top.sv
// Channel   Handshake                 Payload
// pixel in  i_in_valid / o_in_ready   i_red_in i_green_in i_blue_in i_alpha_in i_mask_value
// result    o_out_valid / i_out_ready o_is_summary o_*_out o_box_* o_too_small o_last
// config    APB psel/penable/pready   paddr pwrite pwdata prdata
//
// One pixel per clock sustained while the result side takes every result; the
// input register feeds the result buffer directly. The last pixel of a region
// gives two results, so the summary takes an extra output slot, during which
// the input register holds its request. Synchronous active-low reset; no
// clearing pass, the box reloads at the region's first pixel. Stalls on the
// result side back up through the input register to o_in_ready.
module masked_premultiply_bounding_box_top #(
    parameter int MAX_DIM = mpbb_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel requests
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mpbb_pkg::CH_W-1:0]   i_red_in,
    input  logic [mpbb_pkg::CH_W-1:0]   i_green_in,
    input  logic [mpbb_pkg::CH_W-1:0]   i_blue_in,
    input  logic [mpbb_pkg::CH_W-1:0]   i_alpha_in,
    input  logic [mpbb_pkg::CH_W-1:0]   i_mask_value,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_is_summary,
    output logic [mpbb_pkg::CH_W-1:0]   o_red_out,
    output logic [mpbb_pkg::CH_W-1:0]   o_green_out,
    output logic [mpbb_pkg::CH_W-1:0]   o_blue_out,
    output logic [mpbb_pkg::CH_W-1:0]   o_alpha_out,
    output logic [mpbb_pkg::BOX_W-1:0]  o_box_left,
    output logic [mpbb_pkg::BOX_W-1:0]  o_box_right,
    output logic [mpbb_pkg::BOX_W-1:0]  o_box_top,
    output logic [mpbb_pkg::BOX_W-1:0]  o_box_bottom,
    output logic                        o_too_small,
    output logic                        o_last,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpbb_pkg::APB_AW-1:0] paddr,
    input  logic [mpbb_pkg::APB_DW-1:0] pwdata,
    output logic [mpbb_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    // ---------------- configuration registers ----------------
    mpbb_pkg::t_cfg     r_cfg;
    mpbb_pkg::t_reg_idx reg_idx;
    logic               cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = mpbb_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= mpbb_pkg::WIDTH_RST;
            r_cfg.height  <= mpbb_pkg::HEIGHT_RST;
            r_cfg.thresh  <= mpbb_pkg::THRESH_RST;
            r_cfg.min_box <= mpbb_pkg::MIN_BOX_RST;
        end else if (cfg_we) begin
            unique case (reg_idx)
                mpbb_pkg::REG_WIDTH:   r_cfg.width   <= pwdata[mpbb_pkg::DIM_W-1:0];
                mpbb_pkg::REG_HEIGHT:  r_cfg.height  <= pwdata[mpbb_pkg::DIM_W-1:0];
                mpbb_pkg::REG_THRESH:  r_cfg.thresh  <= pwdata[mpbb_pkg::CH_W-1:0];
                mpbb_pkg::REG_MIN_BOX: r_cfg.min_box <= pwdata[mpbb_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mpbb_pkg::REG_WIDTH:   prdata = mpbb_pkg::APB_DW'(r_cfg.width);
            mpbb_pkg::REG_HEIGHT:  prdata = mpbb_pkg::APB_DW'(r_cfg.height);
            mpbb_pkg::REG_THRESH:  prdata = mpbb_pkg::APB_DW'(r_cfg.thresh);
            mpbb_pkg::REG_MIN_BOX: prdata = mpbb_pkg::APB_DW'(r_cfg.min_box);
            default:               prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic                      r_in_v;
    logic [mpbb_pkg::CH_W-1:0] r_red, r_green, r_blue, r_alpha, r_mask;
    logic                      in_take;
    logic                      advance;   // input register moves into the result buffer
    logic                      can_take;

    assign advance    = r_in_v && can_take;
    assign o_in_ready = !r_in_v || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_take) begin
            r_in_v <= 1'b1;
        end else if (advance) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_red   <= i_red_in;
            r_green <= i_green_in;
            r_blue  <= i_blue_in;
            r_alpha <= i_alpha_in;
            r_mask  <= i_mask_value;
        end
    end

    // ---------------- single-pass compute ----------------
    mpbb_pkg::t_pix    pix;
    mpbb_pkg::t_box    box;
    logic              end_region;
    mpbb_pkg::t_out_wr out_wr;

    mpbb_premul u_premul (
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .i_alpha (r_alpha),
        .i_mask  (r_mask),
        .o_pix   (pix)
    );

    // raster counters and box edges step once per pixel leaving the input register
    mpbb_box #(
        .MAX_DIM (MAX_DIM)
    ) u_box (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_step       (advance),
        .i_alpha      (pix.alpha),
        .o_box        (box),
        .o_end_region (end_region)
    );

    always_comb begin
        out_wr.pix_we = advance;
        out_wr.sum_we = advance && end_region;
    end

    // ---------------- result buffer ----------------
    logic           show_sum;
    mpbb_pkg::t_pix out_pix;
    mpbb_pkg::t_box out_box;

    mpbb_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (out_wr),
        .i_pix      (pix),
        .i_box      (box),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_show_sum (show_sum),
        .o_pix      (out_pix),
        .o_box      (out_box),
        .o_can_take (can_take)
    );

    // pixel results carry zero box fields, summaries zero colour
    always_comb begin
        o_is_summary = show_sum;
        o_last       = show_sum;
        o_red_out    = show_sum ? '0 : out_pix.red;
        o_green_out  = show_sum ? '0 : out_pix.green;
        o_blue_out   = show_sum ? '0 : out_pix.blue;
        o_alpha_out  = show_sum ? '0 : out_pix.alpha;
        o_box_left   = show_sum ? out_box.left   : '0;
        o_box_right  = show_sum ? out_box.right  : '0;
        o_box_top    = show_sum ? out_box.top    : '0;
        o_box_bottom = show_sum ? out_box.bottom : '0;
        o_too_small  = show_sum && out_box.too_small;
    end

endmodule

// File: design/mpbb_premul.sv
module mpbb_premul (
    input  logic [mpbb_pkg::CH_W-1:0] i_red,
    input  logic [mpbb_pkg::CH_W-1:0] i_green,
    input  logic [mpbb_pkg::CH_W-1:0] i_blue,
    input  logic [mpbb_pkg::CH_W-1:0] i_alpha,
    input  logic [mpbb_pkg::CH_W-1:0] i_mask,
    output mpbb_pkg::t_pix            o_pix
);

    logic [mpbb_pkg::CH_W-1:0]   alpha;
    logic [2*mpbb_pkg::CH_W-1:0] prod_r;
    logic [2*mpbb_pkg::CH_W-1:0] prod_g;
    logic [2*mpbb_pkg::CH_W-1:0] prod_b;

    assign alpha  = (i_alpha < i_mask) ? i_alpha : i_mask;
    assign prod_r = i_red   * alpha;
    assign prod_g = i_green * alpha;
    assign prod_b = i_blue  * alpha;

    // keep the high byte: (c * a) >> 8
    always_comb begin
        o_pix.red   = prod_r[2*mpbb_pkg::CH_W-1:mpbb_pkg::CH_W];
        o_pix.green = prod_g[2*mpbb_pkg::CH_W-1:mpbb_pkg::CH_W];
        o_pix.blue  = prod_b[2*mpbb_pkg::CH_W-1:mpbb_pkg::CH_W];
        o_pix.alpha = alpha;
    end

endmodule

// File: design/mpbb_box.sv
module mpbb_box #(
    parameter int MAX_DIM = mpbb_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpbb_pkg::t_cfg            i_cfg,
    input  logic                      i_step,
    input  logic [mpbb_pkg::CH_W-1:0] i_alpha,
    output mpbb_pkg::t_box            o_box,
    output logic                      o_end_region
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = $clog2(MAX_DIM + 1);
    localparam int SW = ((EW > mpbb_pkg::DIM_W) ? EW : mpbb_pkg::DIM_W) + 1;
    localparam int XW = mpbb_pkg::DIM_W + 1;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [EW-1:0] r_left, n_left;
    logic [EW-1:0] r_right, n_right;
    logic [EW-1:0] r_top, n_top;
    logic [EW-1:0] r_bottom, n_bottom;

    logic [EW-1:0] w_eff, h_eff;
    logic [EW-1:0] base_left, base_right, base_top, base_bottom;
    logic [EW-1:0] col_e, row_e;
    logic          first, hit, end_row;

    // zero acts as one, oversize clamps to MAX_DIM
    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = EW'(1);
        end else if ({1'b0, i_cfg.width} > XW'(MAX_DIM)) begin
            w_eff = EW'(MAX_DIM);
        end else begin
            w_eff = EW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = EW'(1);
        end else if ({1'b0, i_cfg.height} > XW'(MAX_DIM)) begin
            h_eff = EW'(MAX_DIM);
        end else begin
            h_eff = EW'(i_cfg.height);
        end
    end

    assign first = (r_col == '0) && (r_row == '0);
    assign col_e = EW'(r_col);
    assign row_e = EW'(r_row);
    assign hit   = i_alpha > i_cfg.thresh;

    always_comb begin
        base_left   = first ? w_eff : r_left;
        base_right  = first ? '0    : r_right;
        base_top    = first ? h_eff : r_top;
        base_bottom = first ? '0    : r_bottom;

        n_left   = (hit && col_e < base_left)   ? col_e : base_left;
        n_right  = (hit && col_e > base_right)  ? col_e : base_right;
        n_top    = (hit && row_e < base_top)    ? row_e : base_top;
        n_bottom = (hit && row_e > base_bottom) ? row_e : base_bottom;

        end_row      = (col_e + EW'(1)) >= w_eff;
        o_end_region = end_row && ((row_e + EW'(1)) >= h_eff);

        if (end_row) begin
            n_col = '0;
            n_row = o_end_region ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // summary view of the box after the current pixel
    always_comb begin
        o_box.left      = mpbb_pkg::BOX_W'(n_left);
        o_box.right     = mpbb_pkg::BOX_W'(n_right);
        o_box.top       = mpbb_pkg::BOX_W'(n_top);
        o_box.bottom    = mpbb_pkg::BOX_W'(n_bottom);
        o_box.too_small = (SW'(n_right) < SW'(n_left) + SW'(i_cfg.min_box)) ||
                          (SW'(n_bottom) < SW'(n_top) + SW'(i_cfg.min_box));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= w_eff;
            r_right  <= '0;
            r_top    <= h_eff;
            r_bottom <= '0;
        end else if (i_step) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_left   <= n_left;
            r_right  <= n_right;
            r_top    <= n_top;
            r_bottom <= n_bottom;
        end
    end

endmodule

// File: design/mpbb_obuf.sv
module mpbb_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpbb_pkg::t_out_wr i_wr,
    input  mpbb_pkg::t_pix    i_pix,
    input  mpbb_pkg::t_box    i_box,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_show_sum,
    output mpbb_pkg::t_pix    o_pix,
    output mpbb_pkg::t_box    o_box,
    output logic              o_can_take
);

    logic           r_pix_v, n_pix_v;
    logic           r_sum_v, n_sum_v;
    mpbb_pkg::t_pix r_pix;
    mpbb_pkg::t_box r_box;

    // pixel result always leaves before its summary
    assign o_valid    = r_pix_v || r_sum_v;
    assign o_show_sum = r_sum_v && !r_pix_v;
    assign o_pix      = r_pix;
    assign o_box      = r_box;
    // free next cycle only if the buffer drains to empty
    assign o_can_take = (!r_pix_v && !r_sum_v) || (i_ready && (r_pix_v != r_sum_v));

    always_comb begin
        n_pix_v = i_wr.pix_we || (r_pix_v && !i_ready);
        n_sum_v = i_wr.sum_we || (r_sum_v && !(i_ready && !r_pix_v));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_v <= 1'b0;
            r_sum_v <= 1'b0;
        end else begin
            r_pix_v <= n_pix_v;
            r_sum_v <= n_sum_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.pix_we) begin
            r_pix <= i_pix;
        end
        if (i_wr.sum_we) begin
            r_box <= i_box;
        end
    end

endmodule

// File: design/mpbb_checker.sv
`include "assert_macros.svh"

module mpbb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_is_summary,
    input logic [mpbb_pkg::CH_W-1:0]  o_red_out,
    input logic [mpbb_pkg::CH_W-1:0]  o_green_out,
    input logic [mpbb_pkg::CH_W-1:0]  o_blue_out,
    input logic [mpbb_pkg::CH_W-1:0]  o_alpha_out,
    input logic [mpbb_pkg::BOX_W-1:0] o_box_left,
    input logic [mpbb_pkg::BOX_W-1:0] o_box_right,
    input logic [mpbb_pkg::BOX_W-1:0] o_box_top,
    input logic [mpbb_pkg::BOX_W-1:0] o_box_bottom,
    input logic                       o_too_small,
    input logic                       o_last
);

    `ASSERT_IMPL(a_last_is_sum, i_clk, i_rst_n, o_out_valid, o_last == o_is_summary, "last flag differs from summary flag")

    `ASSERT_IMPL(a_sum_no_colour, i_clk, i_rst_n, o_out_valid && o_is_summary, (o_red_out == '0) && (o_green_out == '0) && (o_blue_out == '0) && (o_alpha_out == '0), "summary carries colour")

    `ASSERT_IMPL(a_pix_no_box, i_clk, i_rst_n, o_out_valid && !o_is_summary, (o_box_left == '0) && (o_box_right == '0) && (o_box_top == '0) && (o_box_bottom == '0) && !o_too_small, "pixel result carries box")

    `ASSERT_IMPL(a_colour_le_alpha, i_clk, i_rst_n, o_out_valid && !o_is_summary, (o_red_out <= o_alpha_out) && (o_green_out <= o_alpha_out) && (o_blue_out <= o_alpha_out), "premultiplied colour above alpha")

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

endmodule

bind masked_premultiply_bounding_box_top mpbb_checker u_mpbb_checker (.*);

// File: tb/testbench.sv
module testbench;

    // Cycles without any handshake, while work is outstanding, before we give up.
    // Worst honest stall is the long receiver hold-off plus the longest gap.
    localparam int STALL_LIMIT = 2000;
    // Long receiver hold-off used to back the block up to its input.
    localparam int HOLD_OFF    = 300;
    // Random part stops once exactly this many pixels have gone in.
    localparam int RANDOM_PIXELS = 400;
    // Pixels sent in each of the clamped-size phases.
    localparam int CLAMP_PIXELS  = 48;

    // One pixel request as offered on the input channel.
    typedef struct packed {
        logic [mpbb_pkg::CH_W-1:0] red;
        logic [mpbb_pkg::CH_W-1:0] green;
        logic [mpbb_pkg::CH_W-1:0] blue;
        logic [mpbb_pkg::CH_W-1:0] alpha;
        logic [mpbb_pkg::CH_W-1:0] mask;
    } t_pixel_req;

    // One result as it should appear on the output channel.
    typedef struct packed {
        logic                       summary;
        logic [mpbb_pkg::CH_W-1:0]  red;
        logic [mpbb_pkg::CH_W-1:0]  green;
        logic [mpbb_pkg::CH_W-1:0]  blue;
        logic [mpbb_pkg::CH_W-1:0]  alpha;
        logic [mpbb_pkg::BOX_W-1:0] left;
        logic [mpbb_pkg::BOX_W-1:0] right;
        logic [mpbb_pkg::BOX_W-1:0] top;
        logic [mpbb_pkg::BOX_W-1:0] bottom;
        logic                       too_small;
        logic                       last;
    } t_result;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;

    logic                        i_in_valid   = 1'b0;
    logic                        o_in_ready;
    logic [mpbb_pkg::CH_W-1:0]   i_red_in     = '0;
    logic [mpbb_pkg::CH_W-1:0]   i_green_in   = '0;
    logic [mpbb_pkg::CH_W-1:0]   i_blue_in    = '0;
    logic [mpbb_pkg::CH_W-1:0]   i_alpha_in   = '0;
    logic [mpbb_pkg::CH_W-1:0]   i_mask_value = '0;

    logic                        o_out_valid;
    logic                        i_out_ready  = 1'b0;
    logic                        o_is_summary;
    logic [mpbb_pkg::CH_W-1:0]   o_red_out;
    logic [mpbb_pkg::CH_W-1:0]   o_green_out;
    logic [mpbb_pkg::CH_W-1:0]   o_blue_out;
    logic [mpbb_pkg::CH_W-1:0]   o_alpha_out;
    logic [mpbb_pkg::BOX_W-1:0]  o_box_left;
    logic [mpbb_pkg::BOX_W-1:0]  o_box_right;
    logic [mpbb_pkg::BOX_W-1:0]  o_box_top;
    logic [mpbb_pkg::BOX_W-1:0]  o_box_bottom;
    logic                        o_too_small;
    logic                        o_last;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [mpbb_pkg::APB_AW-1:0] paddr   = '0;
    logic [mpbb_pkg::APB_DW-1:0] pwdata  = '0;
    logic [mpbb_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    // Pixels waiting to be offered, and results the block still owes us.
    t_pixel_req pixel_queue[$];
    t_result    awaited_results[$];

    int errors       = 0;
    int results_seen = 0;
    int idle_cycles  = 0;

    // Shadow of the register file as the block should see it.
    int shadow_width   = 2048;
    int shadow_height  = 2048;
    int shadow_thresh  = 100;
    int shadow_min_box = 10;

    // Shadow of the raster position and the running box.
    int px_col = 0;
    int px_row = 0;
    int box_l  = 2048;
    int box_r  = 0;
    int box_t  = 2048;
    int box_b  = 0;

    // Handshake bookkeeping for the clocked processes.
    logic in_taken      = 1'b0;
    int   tx_gap        = 0;
    int   tx_run        = 0;
    int   rx_gap        = 0;
    int   rx_run        = 0;
    int   hold_left     = 0;
    bit   pressure_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    masked_premultiply_bounding_box_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .i_mask_value (i_mask_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_is_summary (o_is_summary),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_box_left   (o_box_left),
        .o_box_right  (o_box_right),
        .o_box_top    (o_box_top),
        .o_box_bottom (o_box_bottom),
        .o_too_small  (o_too_small),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Out-of-range sizes: 0 behaves as 1, anything past the maximum clamps.
    function automatic int dim_used(input int v);
        if (v == 0) return 1;
        if (v > mpbb_pkg::MAX_DIM_DEF) return mpbb_pkg::MAX_DIM_DEF;
        return v;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int run_left);
        int r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            run_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random pixel: a mix of see-through background, opaque foreground and
    // fully random alpha/mask, so boxes come out of every shape.
    function automatic t_pixel_req make_pixel();
        t_pixel_req px;
        int         r;
        px.red   = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.blue  = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 35) begin
            px.alpha = 8'($urandom_range(0, 50));
            px.mask  = 8'($urandom_range(0, 255));
        end else if (r < 55) begin
            px.alpha = 8'hff;
            px.mask  = 8'($urandom_range(128, 255));
        end else begin
            px.alpha = 8'($urandom_range(0, 255));
            px.mask  = 8'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // Append to the tail of the pending and awaited queues.
    task automatic enqueue_pixel(input t_pixel_req px);
        pixel_queue.insert(pixel_queue.size(), px);
    endtask

    task automatic add_awaited(input t_result res);
        awaited_results.insert(awaited_results.size(), res);
    endtask

    // Work out what one accepted pixel request produces: a pixel result, and
    // after the region's last pixel a summary with the box.
    task automatic premultiply_and_track(input t_pixel_req px);
        int      w;
        int      h;
        int      a;
        bit      end_row;
        bit      end_region;
        t_result res;
        w = dim_used(shadow_width);
        h = dim_used(shadow_height);
        a = (px.alpha < px.mask) ? int'(px.alpha) : int'(px.mask);

        // box reloads from the live registers at the region's first pixel
        if (px_col == 0 && px_row == 0) begin
            box_l = w;
            box_r = 0;
            box_t = h;
            box_b = 0;
        end
        if (a > shadow_thresh) begin
            if (px_col < box_l) box_l = px_col;
            if (px_col > box_r) box_r = px_col;
            if (px_row < box_t) box_t = px_row;
            if (px_row > box_b) box_b = px_row;
        end

        res       = '0;
        res.red   = 8'((int'(px.red) * a) >> 8);
        res.green = 8'((int'(px.green) * a) >> 8);
        res.blue  = 8'((int'(px.blue) * a) >> 8);
        res.alpha = 8'(a);
        add_awaited(res);

        // a size shrunk under the current position ends the row/region at once
        end_row    = (px_col + 1 >= w);
        end_region = end_row && (px_row + 1 >= h);
        if (end_row) begin
            px_col = 0;
            px_row = end_region ? 0 : px_row + 1;
        end else begin
            px_col = px_col + 1;
        end

        if (end_region) begin
            res           = '0;
            res.summary   = 1'b1;
            res.left      = 12'(box_l);
            res.right     = 12'(box_r);
            res.top       = 12'(box_t);
            res.bottom    = 12'(box_b);
            // empty box has negative extent, so always flags
            res.too_small = (box_r < box_l + shadow_min_box) ||
                            (box_b < box_t + shadow_min_box);
            res.last      = 1'b1;
            add_awaited(res);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: sample both channels and the register port at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_result    want;
        t_pixel_req seen;
        if (i_rst_n) begin
            // keep the shadow registers in step with the block
            if (psel && penable && pwrite && pready) begin
                case (mpbb_pkg::t_reg_idx'(paddr[3:2]))
                    mpbb_pkg::REG_WIDTH:
                        shadow_width   = int'(pwdata[mpbb_pkg::DIM_W-1:0]);
                    mpbb_pkg::REG_HEIGHT:
                        shadow_height  = int'(pwdata[mpbb_pkg::DIM_W-1:0]);
                    mpbb_pkg::REG_THRESH:
                        shadow_thresh  = int'(pwdata[mpbb_pkg::CH_W-1:0]);
                    mpbb_pkg::REG_MIN_BOX:
                        shadow_min_box = int'(pwdata[mpbb_pkg::DIM_W-1:0]);
                    default: ;
                endcase
            end

            // predict first, so a same-edge result still meets the oldest entry
            if (i_in_valid && o_in_ready) begin
                seen = '{i_red_in, i_green_in, i_blue_in, i_alpha_in, i_mask_value};
                premultiply_and_track(seen);
            end

            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("result arrived with nothing awaited");
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("is_summary", want.summary,   o_is_summary);
                    check_field("red_out",    want.red,       o_red_out);
                    check_field("green_out",  want.green,     o_green_out);
                    check_field("blue_out",   want.blue,      o_blue_out);
                    check_field("alpha_out",  want.alpha,     o_alpha_out);
                    check_field("box_left",   want.left,      o_box_left);
                    check_field("box_right",  want.right,     o_box_right);
                    check_field("box_top",    want.top,       o_box_top);
                    check_field("box_bottom", want.bottom,    o_box_bottom);
                    check_field("too_small",  want.too_small, o_too_small);
                    check_field("last",       want.last,      o_last);
                end
            end

            in_taken <= i_in_valid && o_in_ready;

            // watchdog: only counts while something is still owed
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                    (psel && penable)) begin
                idle_cycles = 0;
            end else if (pixel_queue.size() != 0 || awaited_results.size() != 0 ||
                    i_in_valid) begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Driver: offer pixel requests at the falling edge, holding each until taken.
    always @(negedge i_clk) begin : driver
        t_pixel_req px;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                px = pixel_queue.pop_front();
                i_red_in     <= px.red;
                i_green_in   <= px.green;
                i_blue_in    <= px.blue;
                i_alpha_in   <= px.alpha;
                i_mask_value <= px.mask;
                i_in_valid   <= 1'b1;
                tx_gap = pick_gap(tx_run);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off while the sender
    // still has plenty queued, so the block fills and drops o_in_ready.
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!pressure_done && results_seen >= 150 && pixel_queue.size() > 20) begin
            pressure_done = 1'b1;
            hold_left = HOLD_OFF;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_gap = pick_gap(rx_run);
        end
    end

    // Setup cycle then access cycle; the write lands on the access edge.
    task automatic reg_write(input mpbb_pkg::t_reg_idx idx, input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every queued request has gone in and every result is out,
    // then let the pipeline settle.
    task automatic drain();
        while (pixel_queue.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Registers only change once the block has gone quiet.
    task automatic set_config(input int w, input int h, input int thr, input int mb);
        drain();
        reg_write(mpbb_pkg::REG_WIDTH,   w);
        reg_write(mpbb_pkg::REG_HEIGHT,  h);
        reg_write(mpbb_pkg::REG_THRESH,  thr);
        reg_write(mpbb_pkg::REG_MIN_BOX, mb);
    endtask

    initial begin : stimulus
        int w;
        int h;
        int thr;
        int mb;
        int r;
        int n;
        int random_sent;
        random_sent = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a few pixels on the reset settings: mid-row of a full-size region
        repeat (3) enqueue_pixel(make_pixel());

        // shrink the region mid-row: column 3 of width 4 ends the row at once
        set_config(4, 2, 100, 0);
        enqueue_pixel(t_pixel_req'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
        enqueue_pixel(t_pixel_req'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        // alpha equal to threshold stays out of the box, one above goes in
        enqueue_pixel(t_pixel_req'{8'd255, 8'd128, 8'd1,   8'd100, 8'd255});
        enqueue_pixel(t_pixel_req'{8'd255, 8'd255, 8'd255, 8'd101, 8'd255});
        // zero mask, then zero alpha: all channels zero
        enqueue_pixel(t_pixel_req'{8'd200, 8'd100, 8'd50,  8'd255, 8'd0});
        enqueue_pixel(t_pixel_req'{8'd200, 8'd100, 8'd50,  8'd0,   8'd255});
        // mask limits, then alpha limits
        enqueue_pixel(t_pixel_req'{8'd17,  8'd34,  8'd68,  8'd200, 8'd150});
        enqueue_pixel(t_pixel_req'{8'd17,  8'd34,  8'd68,  8'd150, 8'd200});

        // top threshold: nothing ever exceeds it, so the box stays empty
        set_config(4, 2, 255, 0);
        repeat (8)
            enqueue_pixel(t_pixel_req'{8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255, 8'd255});

        // one-pixel regions, zero threshold, minimum box equal to the maximum size
        set_config(1, 1, 0, 2048);
        enqueue_pixel(t_pixel_req'{8'd9,   8'd9,   8'd9,   8'd1,   8'd1});
        enqueue_pixel(t_pixel_req'{8'd9,   8'd9,   8'd9,   8'd0,   8'd77});
        enqueue_pixel(t_pixel_req'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255});

        // random phases: whole regions with random content, sometimes a
        // dangling part-region so the next setting lands mid-region
        while (random_sent < RANDOM_PIXELS) begin
            r = $urandom_range(0, 99);
            w = (r < 70) ? $urandom_range(1, 8) : (r < 90) ? $urandom_range(9, 40) :
                (r < 95) ? 0 : 1;
            r = $urandom_range(0, 99);
            h = (r < 70) ? $urandom_range(1, 6) : (r < 90) ? $urandom_range(7, 20) :
                (r < 95) ? 0 : 1;
            r = $urandom_range(0, 99);
            thr = (r < 10) ? 0 : (r < 20) ? 255 : (r < 30) ? $urandom_range(1, 20) :
                  $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            mb = (r < 15) ? 0 : (r < 25) ? 2048 : $urandom_range(1, 8);
            set_config(w, h, thr, mb);

            n = $urandom_range(1, 3) * dim_used(w) * dim_used(h);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, dim_used(w) * dim_used(h));
            if (n > RANDOM_PIXELS - random_sent)
                n = RANDOM_PIXELS - random_sent;
            repeat (n) enqueue_pixel(make_pixel());
            random_sent += n;
        end

        // oversized width and zero height: a part row, well past any small width
        set_config(4095, 0, $urandom_range(0, 255), 2048);
        repeat (CLAMP_PIXELS) enqueue_pixel(make_pixel());

        // and the other way round: one column, oversized height
        set_config(0, 2500, $urandom_range(0, 255), $urandom_range(0, 3));
        repeat (CLAMP_PIXELS) enqueue_pixel(make_pixel());

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
